// ===== src/btc_pkg.sv =====
// shared types and constants for the boolean transitive closure block
package btc_pkg;

	localparam int VERT_W    = 6;
	localparam int NODE_W    = 7;
	localparam int COUNT_W   = 13;
	localparam int NUM_VERT  = 1 << VERT_W;
	localparam logic [NODE_W-1:0]  NODE_COUNT_RST = 7'd64;
	localparam logic [COUNT_W-1:0] COUNT_MAX      = 13'd8191;

	typedef enum logic [1:0] {
		OP_SET_EDGE = 2'd0,
		OP_ADD_SRC  = 2'd1,
		OP_RUN      = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EDGE,
		S_PIV,
		S_PIVW,
		S_SWEEP,
		S_CNT,
		S_DRAIN,
		S_DONE
	} state_t;

endpackage

// ===== src/btc_row_mem.sv =====
// adjacency row memory with per-row valid bits and registered read
module btc_row_mem #(
	parameter int ROWS = 64,
	parameter int RAW  = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            clr,
	input  logic [RAW-1:0]  rd_addr,
	output logic [ROWS-1:0] rd_row,
	input  logic            wr_en,
	input  logic [RAW-1:0]  wr_addr,
	input  logic [ROWS-1:0] wr_data
);

	logic [ROWS-1:0] mem [ROWS];
	logic [ROWS-1:0] vld_q;
	logic [ROWS-1:0] rd_data_q;
	logic            rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr];
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a row never written since the last clear reads as zero
	assign rd_row = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== src/boolean_transitive_closure.sv =====
// top level: warshall transitive closure over a stored adjacency matrix with reach counting
//
// Command port: a word is taken when start is high and busy is low. operation selects
// set edge bit (edge_from, edge_to), add source vertex (source_vertex), run, or clear.
// Set edge does a read-modify-write of one row.
// Run closes the first n rows in place, n = min(node_count, MAX_NODES, 64), then sums
// the set bits of each listed source's row. The closure walks one pivot at a time:
// it fetches the pivot row, then sweeps the rows in order, reading each from the row
// memory and writing it back ORed with the pivot row when it holds the pivot bit.
// done pulses for one cycle with reach_count on its last cycle; only run gives a
// result, and the receiver has no way to stall it.
// node_count is to be written through cfg_we/cfg_wdata only while the block is idle;
// the block itself does not enforce this.
// Reset clears the matrix (per-row valid bits, no sweep needed), empties the
// source list and sets node_count to 64. Entries of the source list past the
// current fill count are never read.
module boolean_transitive_closure #(
	parameter int MAX_NODES   = 64,
	parameter int MAX_SOURCES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  operation,
	input  logic [btc_pkg::VERT_W-1:0]  edge_from,
	input  logic [btc_pkg::VERT_W-1:0]  edge_to,
	input  logic [btc_pkg::VERT_W-1:0]  source_vertex,
	output logic                        done,
	output logic [btc_pkg::COUNT_W-1:0] reach_count,
	input  logic                        cfg_we,
	input  logic [btc_pkg::NODE_W-1:0]  cfg_wdata
);

	localparam int NW    = btc_pkg::NODE_W;
	localparam int CW    = btc_pkg::COUNT_W;
	localparam int VW    = btc_pkg::VERT_W;
	localparam int ROWS  = (MAX_NODES < btc_pkg::NUM_VERT) ? MAX_NODES : btc_pkg::NUM_VERT;
	localparam int RAW   = $clog2(ROWS);
	localparam int SAW   = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int STW   = $clog2(MAX_SOURCES + 1);
	localparam int POP_W = $clog2(ROWS + 1);
	localparam int NCH   = (ROWS + 7) / 8;

	btc_pkg::state_t state_q, state_d, cnt_entry;

	logic [NW-1:0]   node_count_q;
	logic [NW-1:0]   n_act, n_last;
	logic [STW-1:0]  src_total_q, src_last;
	logic [RAW-1:0]  k_q, wi_q;
	logic [SAW-1:0]  c_q;
	logic [RAW-1:0]  from_q, to_q;
	logic [ROWS-1:0] pivot_q, row_mask, row_rd, edge_bit;
	logic [VW-1:0]   src_mem [MAX_SOURCES];
	logic [VW-1:0]   src_s1;
	logic            rng_s2;
	logic [3:0]      chunk_s3 [NCH];
	logic [3:0]      chunk_d  [NCH];
	logic [POP_W-1:0] pop_s4, pop_d;
	logic            v_s1, v_s2, v_s3, v_s4;
	logic [CW-1:0]   acc_q;
	logic [CW:0]     acc_sum;
	logic            accept, edge_ok, row_last, piv_last, cnt_last, mem_clr;
	logic            mem_we;
	logic [RAW-1:0]  mem_rd_addr, mem_wr_addr;
	logic [ROWS-1:0] mem_wr_data;

	assign accept   = start && (state_q == btc_pkg::S_IDLE);
	assign n_act    = (32'(node_count_q) > ROWS) ? NW'(ROWS) : node_count_q;
	assign n_last   = n_act - NW'(1);
	assign row_last = (NW'(wi_q) == n_last);
	assign piv_last = (NW'(k_q) == n_last);
	assign src_last = src_total_q - STW'(1);
	assign cnt_last = (STW'(c_q) == src_last);
	assign edge_ok  = (32'(edge_from) < MAX_NODES) && (32'(edge_to) < MAX_NODES);
	assign mem_clr  = accept && (btc_pkg::op_t'(operation) == btc_pkg::OP_CLEAR);
	assign cnt_entry = (src_total_q != '0) ? btc_pkg::S_CNT : btc_pkg::S_DRAIN;

	always_comb begin
		row_mask = '0;
		for (int c = 0; c < ROWS; c++) begin
			row_mask[c] = (c < int'(n_act));
		end
	end

	always_comb begin
		edge_bit = '0;
		edge_bit[to_q] = 1'b1;
	end

	btc_row_mem #(
		.ROWS(ROWS),
		.RAW (RAW)
	) u_row_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (mem_clr),
		.rd_addr(mem_rd_addr),
		.rd_row (row_rd),
		.wr_en  (mem_we),
		.wr_addr(mem_wr_addr),
		.wr_data(mem_wr_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			btc_pkg::S_IDLE: begin
				if (start) begin
					case (btc_pkg::op_t'(operation))
						btc_pkg::OP_SET_EDGE: state_d = edge_ok ? btc_pkg::S_EDGE : btc_pkg::S_IDLE;
						btc_pkg::OP_RUN:      state_d = (n_act != '0) ? btc_pkg::S_PIV : cnt_entry;
						default:              state_d = btc_pkg::S_IDLE;
					endcase
				end
			end
			btc_pkg::S_EDGE:  state_d = btc_pkg::S_IDLE;
			btc_pkg::S_PIV:   state_d = btc_pkg::S_PIVW;
			btc_pkg::S_PIVW:  state_d = btc_pkg::S_SWEEP;
			btc_pkg::S_SWEEP: begin
				if (row_last) begin
					state_d = piv_last ? cnt_entry : btc_pkg::S_PIV;
				end
			end
			btc_pkg::S_CNT: begin
				if (cnt_last) begin
					state_d = btc_pkg::S_DRAIN;
				end
			end
			btc_pkg::S_DRAIN: begin
				if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
					state_d = btc_pkg::S_DONE;
				end
			end
			btc_pkg::S_DONE:  state_d = btc_pkg::S_IDLE;
			default:          state_d = btc_pkg::S_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		mem_rd_addr = wi_q + RAW'(1);
		mem_we      = 1'b0;
		mem_wr_addr = wi_q;
		mem_wr_data = row_rd | pivot_q;
		busy        = (state_q != btc_pkg::S_IDLE);
		done        = 1'b0;
		case (state_q)
			btc_pkg::S_IDLE:  mem_rd_addr = edge_from[RAW-1:0];
			btc_pkg::S_EDGE: begin
				mem_we      = 1'b1;
				mem_wr_addr = from_q;
				mem_wr_data = row_rd | edge_bit;
			end
			btc_pkg::S_PIV:   mem_rd_addr = k_q;
			btc_pkg::S_PIVW:  mem_rd_addr = '0;
			btc_pkg::S_SWEEP: mem_we = row_rd[k_q];
			btc_pkg::S_CNT,
			btc_pkg::S_DRAIN: mem_rd_addr = src_s1[RAW-1:0];
			btc_pkg::S_DONE:  done = 1'b1;
			default: ;
		endcase
	end

	assign reach_count = acc_q;

	// popcount of the fetched source row, per byte then summed
	always_comb begin
		for (int ch = 0; ch < NCH; ch++) begin
			chunk_d[ch] = '0;
			for (int b = 0; b < 8; b++) begin
				if (ch * 8 + b < ROWS) begin
					chunk_d[ch] = chunk_d[ch] + 4'(row_rd[ch * 8 + b] & row_mask[ch * 8 + b]);
				end
			end
		end
	end

	always_comb begin
		pop_d = '0;
		for (int ch = 0; ch < NCH; ch++) begin
			pop_d = pop_d + POP_W'(chunk_s3[ch]);
		end
	end

	assign acc_sum = {1'b0, acc_q} + (CW + 1)'(pop_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= btc_pkg::S_IDLE;
			node_count_q <= btc_pkg::NODE_COUNT_RST;
			src_total_q  <= '0;
			k_q          <= '0;
			wi_q         <= '0;
			c_q          <= '0;
			v_s1         <= 1'b0;
			v_s2         <= 1'b0;
			v_s3         <= 1'b0;
			v_s4         <= 1'b0;
			acc_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (accept) begin
				case (btc_pkg::op_t'(operation))
					btc_pkg::OP_ADD_SRC: begin
						if (32'(src_total_q) < MAX_SOURCES) begin
							src_total_q <= src_total_q + STW'(1);
						end
					end
					btc_pkg::OP_RUN: begin
						k_q   <= '0;
						c_q   <= '0;
						acc_q <= '0;
					end
					btc_pkg::OP_CLEAR: src_total_q <= '0;
					default: ;
				endcase
			end
			if (state_q == btc_pkg::S_PIVW) begin
				wi_q <= '0;
			end
			if (state_q == btc_pkg::S_SWEEP) begin
				wi_q <= wi_q + RAW'(1);
				if (row_last) begin
					k_q <= k_q + RAW'(1);
				end
			end
			if (state_q == btc_pkg::S_CNT) begin
				c_q <= c_q + SAW'(1);
			end
			v_s1 <= (state_q == btc_pkg::S_CNT);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (v_s4) begin
				acc_q <= acc_sum[CW] ? btc_pkg::COUNT_MAX : acc_sum[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_q <= edge_from[RAW-1:0];
			to_q   <= edge_to[RAW-1:0];
		end
		if (accept && (btc_pkg::op_t'(operation) == btc_pkg::OP_ADD_SRC)
			&& (32'(src_total_q) < MAX_SOURCES)) begin
			src_mem[src_total_q[SAW-1:0]] <= source_vertex;
		end
		src_s1 <= src_mem[c_q];
		if (state_q == btc_pkg::S_PIVW) begin
			pivot_q <= row_rd & row_mask;
		end
		// sources at or beyond the active vertex count add nothing
		rng_s2 <= (NW'(src_s1) < n_act);
		for (int ch = 0; ch < NCH; ch++) begin
			chunk_s3[ch] <= rng_s2 ? chunk_d[ch] : 4'd0;
		end
		pop_s4 <= pop_d;
	end

endmodule

// ===== tb/sv/btc_checker.sv =====
// checker for the transitive closure block: tracks the command words, predicts counts, compares
`timescale 1ns / 1ps

module btc_checker
	import btc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic [1:0]         operation,
	input  logic [VERT_W-1:0]  edge_from,
	input  logic [VERT_W-1:0]  edge_to,
	input  logic [VERT_W-1:0]  source_vertex,
	input  logic               done,
	input  logic [COUNT_W-1:0] reach_count,
	input  logic               cfg_we,
	input  logic [NODE_W-1:0]  cfg_wdata,
	output int                 fail_count,
	output int                 pending
);

	localparam int SRC_DEPTH = 64;

	logic [NUM_VERT-1:0] adj_rows [NUM_VERT];
	logic [VERT_W-1:0]   src_list [SRC_DEPTH];
	int                  src_fill;
	logic [NODE_W-1:0]   node_cnt;
	logic [COUNT_W-1:0]  count_q [$];

	// closes the first n rows in place, then sums the closed rows of the listed sources
	function automatic logic [COUNT_W-1:0] close_and_count();
		int n;
		int total;
		logic [NUM_VERT-1:0] col_mask;
		n = (node_cnt > NUM_VERT) ? NUM_VERT : int'(node_cnt);
		col_mask = (n >= NUM_VERT) ? '1 : ((64'd1 << n) - 64'd1);
		for (int k = 0; k < n; k++)
			for (int i = 0; i < n; i++)
				if (adj_rows[i][k])
					adj_rows[i] = adj_rows[i] | (adj_rows[k] & col_mask);
		total = 0;
		for (int s = 0; s < src_fill; s++) begin
			if (int'(src_list[s]) < n)
				total += $countones(adj_rows[src_list[s]] & col_mask);
			if (total > int'(COUNT_MAX))
				total = int'(COUNT_MAX);
		end
		return total[COUNT_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VERT; i++)
				adj_rows[i] = '0;
			src_fill = 0;
			node_cnt = NODE_COUNT_RST;
			count_q.delete();
			fail_count = 0;
		end else begin
			// a result belongs to an earlier run, so check it before taking a new word
			if (done) begin
				if (count_q.size() == 0) begin
					$error("reach_count: no result expected, got %0d", reach_count);
					fail_count++;
				end else if (reach_count !== count_q[0]) begin
					$error("reach_count: expected %0d, got %0d", count_q[0], reach_count);
					fail_count++;
					void'(count_q.pop_front());
				end else begin
					void'(count_q.pop_front());
				end
			end
			if (cfg_we)
				node_cnt = cfg_wdata;
			if (start && !busy) begin
				case (op_t'(operation))
					OP_SET_EDGE: adj_rows[edge_from][edge_to] = 1'b1;
					OP_ADD_SRC: begin
						if (src_fill < SRC_DEPTH) begin
							src_list[src_fill] = source_vertex;
							src_fill++;
						end
					end
					OP_RUN: count_q.insert(count_q.size(), close_and_count());
					default: begin
						for (int i = 0; i < NUM_VERT; i++)
							adj_rows[i] = '0;
						src_fill = 0;
					end
				endcase
			end
		end
		pending = count_q.size();
	end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the closure testbench: clock, reset, command stimulus and the verdict
`timescale 1ns / 1ps

module testbench;
	import btc_pkg::*;

	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 160;
	localparam int SRC_DEPTH   = 64;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         operation;
	logic [VERT_W-1:0]  edge_from;
	logic [VERT_W-1:0]  edge_to;
	logic [VERT_W-1:0]  source_vertex;
	logic               done;
	logic [COUNT_W-1:0] reach_count;
	logic               cfg_we;
	logic [NODE_W-1:0]  cfg_wdata;
	int                 fail_count;
	int                 pending;

	// per phase: node count, then percentages of run, clear and add words; the rest set edges
	int node_tab [PHASES] = '{12, 1, 0, 64, 5, 16, 127, 2, 8, 33};
	int run_tab  [PHASES] = '{12, 12, 12, 3, 12, 10, 3, 12, 6, 4};
	int clr_tab  [PHASES] = '{2, 3, 2, 1, 2, 2, 1, 3, 0, 1};
	int add_tab  [PHASES] = '{25, 25, 25, 20, 25, 25, 20, 25, 50, 20};

	bit burst;
	int src_fill;

	boolean_transitive_closure u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.source_vertex (source_vertex),
		.done          (done),
		.reach_count   (reach_count),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	btc_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.operation     (operation),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.source_vertex (source_vertex),
		.done          (done),
		.reach_count   (reach_count),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// start stays high across back-to-back words and drops only when a gap follows
	task automatic send_word(op_t op, int from, int to, int src);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		edge_from <= from[VERT_W-1:0];
		edge_to <= to[VERT_W-1:0];
		source_vertex <= src[VERT_W-1:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == OP_ADD_SRC && src_fill < SRC_DEPTH)
			src_fill++;
		else if (op == OP_CLEAR)
			src_fill = 0;
	endtask

	// node count is only changed once the block has gone quiet
	task automatic write_node_count(int value);
		start <= 1'b0;
		wait (pending == 0);
		repeat (8) @(posedge clk);
		while (busy)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[NODE_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// mostly vertices inside the active range, sometimes anywhere in the field
	function automatic int pick_vertex(int n);
		if (n == 0 || n > NUM_VERT || $urandom_range(0, 7) == 0)
			return $urandom_range(0, NUM_VERT - 1);
		return $urandom_range(0, n - 1);
	endfunction

	initial begin
		#100000000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int n;
		int r;
		int taken;
		start = 1'b0;
		operation = OP_SET_EDGE;
		edge_from = '0;
		edge_to = '0;
		source_vertex = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		burst = 1'b0;
		src_fill = 0;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed words at the reset node count
		send_word(OP_RUN, 0, 0, 0);
		send_word(OP_SET_EDGE, 0, 0, 0);
		send_word(OP_SET_EDGE, 63, 63, 0);
		send_word(OP_SET_EDGE, 0, 63, 0);
		send_word(OP_SET_EDGE, 63, 0, 0);
		send_word(OP_ADD_SRC, 63, 63, 0);
		send_word(OP_ADD_SRC, 0, 0, 63);
		send_word(OP_RUN, 63, 63, 63);
		burst = 1'b1;
		send_word(OP_SET_EDGE, 1, 2, 0);
		send_word(OP_SET_EDGE, 2, 3, 0);
		send_word(OP_SET_EDGE, 0, 1, 0);
		send_word(OP_ADD_SRC, 0, 0, 1);
		send_word(OP_ADD_SRC, 0, 0, 1);
		send_word(OP_RUN, 0, 0, 0);
		burst = 1'b0;
		send_word(OP_CLEAR, 0, 0, 0);
		send_word(OP_RUN, 0, 0, 0);
		send_word(OP_ADD_SRC, 0, 0, 5);
		send_word(OP_SET_EDGE, 5, 5, 0);
		send_word(OP_SET_EDGE, 42, 21, 21);
		send_word(OP_RUN, 0, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			n = node_tab[p];
			write_node_count(n);
			taken = 0;
			while (taken < PHASE_ITEMS) begin
				if (taken % 20 == 0)
					burst = ($urandom_range(0, 3) == 0);
				r = $urandom_range(0, 99);
				if (r < run_tab[p]) begin
					send_word(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 63));
					taken++;
				end else if (r < run_tab[p] + clr_tab[p]) begin
					send_word(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 63));
					taken++;
				end else if (r < run_tab[p] + clr_tab[p] + add_tab[p]) begin
					// adds into a full list are dropped by the block
					if (src_fill < SRC_DEPTH)
						taken++;
					send_word(OP_ADD_SRC, $urandom_range(0, 63), $urandom_range(0, 63),
						pick_vertex(n));
				end else begin
					send_word(OP_SET_EDGE, pick_vertex(n), pick_vertex(n),
						$urandom_range(0, 63));
					taken++;
				end
			end
			burst = 1'b0;
		end

		// let the last word settle, then wait out any run still in progress
		start <= 1'b0;
		@(posedge clk);
		while (busy || pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
